// File: rtl/vdes_pkg.sv
// ----------------------------------------------------------------------------
// vdes_pkg - drive-enable sequencer shared definitions
// State codes, kick codes, register indexes and the field layout of the
// input and result transfers.
// ----------------------------------------------------------------------------
package vdes_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_STARTUP  = 3'd0,
        ST_TS_OFF   = 3'd1,
        ST_TS_ON    = 3'd2,
        ST_ENABLING = 3'd3,
        ST_BUZZER   = 3'd4,
        ST_READY    = 3'd5
    } state_t;

    // Inverter kick command codes
    typedef enum logic [1:0] {
        KICK_NONE    = 2'd0,
        KICK_DISABLE = 2'd1,
        KICK_ENABLE  = 2'd2
    } kick_t;

    localparam int CfgIndexWidth = 2;
    localparam int CfgDataWidth  = 16;

    // Configuration register indexes; other indexes are ignored
    localparam logic [CfgIndexWidth-1:0] REG_OC_THRESHOLD  = 2'd0;
    localparam logic [CfgIndexWidth-1:0] REG_BUZZER_DURATN = 2'd1;

    localparam int ThresholdWidth = 13;
    localparam int DurationWidth  = 16;
    localparam int ElapsedWidth   = 8;
    localparam int CurrentWidth   = 16;
    localparam int ProductWidth   = 17;

    localparam logic [ThresholdWidth-1:0] OcThresholdReset = 13'd100;
    localparam logic [DurationWidth-1:0]  BuzzerDurReset   = 16'd2000;
    localparam logic [3:0]                CurrentScale     = 4'd10;

    localparam int InDataWidth  = 40;
    localparam int OutDataWidth = 16;

    // Input tdata bit positions
    localparam int InTsActive    = 0;
    localparam int InPcOk        = 1;
    localparam int InPcTimedOut  = 2;
    localparam int InPcTried     = 3;
    localparam int InStartButton = 4;
    localparam int InBrake       = 5;
    localparam int InInvReady    = 6;
    localparam int InInvDisabled = 7;
    localparam int InInvTimeout  = 8;
    localparam int InElapsedLo   = 9;
    localparam int InCurrentLo   = 17;

    // Result fields
    typedef struct packed {
        logic   overcurrent;
        logic   inverter_startup;
        logic   force_discharge;
        logic   fault_clear;
        logic   precharge_reset;
        logic   precharge_start;
        kick_t  kick_command;
        logic   lowside_on;
        logic   buzzer_on;
        logic   state_changed;
        state_t vehicle_state;
    } result_t;

endpackage

// File: rtl/vehicle_drive_enable_sequencer_core.sv
// ----------------------------------------------------------------------------
// vehicle_drive_enable_sequencer_core - drive-enable state sequencer
// Runs the six-state drive-enable sequence, one control-loop pass per
// input transfer, and emits state, action pulses and an overcurrent flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer per control-loop pass carrying the
//   tractive-system, precharge, inverter, brake and start-button flags,
//   the milliseconds since the last pass and the accumulator current.
//   Output stream (m_*): one result transfer per input transfer with the
//   new state, the state-change flag, buzzer and low-side levels, the
//   kick command, the one-pass action pulses and the overcurrent flag.
//   Config port: cfg_wr_en / cfg_index / cfg_data; index 0 sets the
//   overcurrent threshold, index 1 the buzzer duration in ms. Write only
//   while no transfer is in flight.
//   The result register is loaded on the edge that takes the input. One
//   pass is taken per cycle while the receiver takes each result; the state
//   machine and buzzer timer are updated in that same edge.
//   Reset puts the sequencer in startup, clears the buzzer timer, loads
//   the register defaults and empties the result register.
//   When the receiver stalls the result is held and s_tready drops until
//   the result is taken; a new input is accepted in the cycle it is taken.
// ----------------------------------------------------------------------------
module vehicle_drive_enable_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata, lowest bit first: ts_active, precharge_ok, precharge_timed_out,
    // precharge_tried, start_button, brake_active, inverter_ready,
    // inverter_disabled, inverter_enable_timeout, elapsed_ms[7:0],
    // accumulator_current[15:0], zero padding[6:0]
    input  logic [vdes_pkg::InDataWidth-1:0]  s_tdata,

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata, lowest bit first: vehicle_state[2:0], state_changed,
    // buzzer_on, lowside_on, kick_command[1:0], precharge_start,
    // precharge_reset, fault_clear, force_discharge, inverter_startup,
    // overcurrent, zero padding[1:0]
    output logic [vdes_pkg::OutDataWidth-1:0] m_tdata,

    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [vdes_pkg::CfgIndexWidth-1:0] cfg_index,
    input  logic [vdes_pkg::CfgDataWidth-1:0]  cfg_data
);

    logic [vdes_pkg::ThresholdWidth-1:0] oc_threshold_reg;
    logic [vdes_pkg::DurationWidth-1:0]  buzzer_dur_reg;
    vdes_pkg::state_t                    state_reg;
    vdes_pkg::state_t                    state_next;
    logic [vdes_pkg::DurationWidth-1:0]  buzzer_elapsed_reg;
    logic [vdes_pkg::DurationWidth-1:0]  buzzer_elapsed_next;
    logic                                m_tvalid_reg;
    vdes_pkg::result_t                   result_reg;
    vdes_pkg::result_t                   result_next;

    logic                                accept;
    logic                                ts, pc_ok, pc_to, pc_tried;
    logic                                start_pressed, brake;
    logic                                inv_ready, inv_disabled, inv_timeout;
    logic [vdes_pkg::ElapsedWidth-1:0]   elapsed_ms;
    logic [vdes_pkg::CurrentWidth-1:0]   current;
    logic [vdes_pkg::DurationWidth:0]    buzzer_sum;
    logic [vdes_pkg::DurationWidth-1:0]  buzzer_sat;
    logic [vdes_pkg::ProductWidth-1:0]   oc_limit;
    vdes_pkg::kick_t                     kick;
    logic                                pc_start;
    logic                                changed;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg};

    // Input field unpacking
    assign ts            = s_tdata[vdes_pkg::InTsActive];
    assign pc_ok         = s_tdata[vdes_pkg::InPcOk];
    assign pc_to         = s_tdata[vdes_pkg::InPcTimedOut];
    assign pc_tried      = s_tdata[vdes_pkg::InPcTried];
    assign start_pressed = !s_tdata[vdes_pkg::InStartButton];
    assign brake         = s_tdata[vdes_pkg::InBrake];
    assign inv_ready     = s_tdata[vdes_pkg::InInvReady];
    assign inv_disabled  = s_tdata[vdes_pkg::InInvDisabled];
    assign inv_timeout   = s_tdata[vdes_pkg::InInvTimeout];
    assign elapsed_ms    = s_tdata[vdes_pkg::InElapsedLo +: vdes_pkg::ElapsedWidth];
    assign current       = s_tdata[vdes_pkg::InCurrentLo +: vdes_pkg::CurrentWidth];

    // Buzzer timer: add this pass's time, saturate at full scale
    assign buzzer_sum = {1'b0, buzzer_elapsed_reg}
                      + {{(vdes_pkg::DurationWidth-vdes_pkg::ElapsedWidth+1){1'b0}}, elapsed_ms};
    assign buzzer_sat = buzzer_sum[vdes_pkg::DurationWidth] ? '1
                      : buzzer_sum[vdes_pkg::DurationWidth-1:0];

    // Overcurrent limit = threshold * 10, at full product width
    assign oc_limit = vdes_pkg::ProductWidth'(oc_threshold_reg)
                    * vdes_pkg::ProductWidth'(vdes_pkg::CurrentScale);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oc_threshold_reg <= vdes_pkg::OcThresholdReset;
            buzzer_dur_reg   <= vdes_pkg::BuzzerDurReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                vdes_pkg::REG_OC_THRESHOLD:
                    oc_threshold_reg <= cfg_data[vdes_pkg::ThresholdWidth-1:0];
                vdes_pkg::REG_BUZZER_DURATN:
                    buzzer_dur_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // State, timer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= vdes_pkg::ST_STARTUP;
            buzzer_elapsed_reg <= '0;
            m_tvalid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg          <= state_next;
                buzzer_elapsed_reg <= buzzer_elapsed_next;
            end
            if (s_tready)
                m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    // Next state, timer and kick command for this pass
    always_comb
    begin
        state_next          = state_reg;
        buzzer_elapsed_next = buzzer_elapsed_reg;
        kick                = vdes_pkg::KICK_NONE;
        pc_start            = 1'b0;
        unique case (state_reg)
            vdes_pkg::ST_TS_OFF:
            begin
                kick     = vdes_pkg::KICK_DISABLE;
                pc_start = !pc_tried || (pc_to && !pc_ok);
                if (pc_ok && !pc_to && ts)
                    state_next = vdes_pkg::ST_TS_ON;
            end
            vdes_pkg::ST_TS_ON:
            begin
                kick = vdes_pkg::KICK_DISABLE;
                // a fault exit wins over the start request
                if (!ts || pc_to)
                    state_next = vdes_pkg::ST_TS_OFF;
                else if (start_pressed && brake)
                    state_next = vdes_pkg::ST_ENABLING;
            end
            vdes_pkg::ST_ENABLING:
            begin
                kick = vdes_pkg::KICK_ENABLE;
                if (!ts || pc_to)
                    state_next = vdes_pkg::ST_TS_OFF;
                else if (inv_timeout)
                    state_next = vdes_pkg::ST_TS_ON;
                else if (inv_ready)
                    state_next = vdes_pkg::ST_BUZZER;
            end
            vdes_pkg::ST_BUZZER:
            begin
                kick                = vdes_pkg::KICK_ENABLE;
                buzzer_elapsed_next = buzzer_sat;
                if (!ts)
                    state_next = vdes_pkg::ST_TS_OFF;
                else if (inv_disabled)
                    state_next = vdes_pkg::ST_TS_ON;
                else if (buzzer_sat >= buzzer_dur_reg)
                    state_next = vdes_pkg::ST_READY;
            end
            vdes_pkg::ST_READY:
            begin
                if (!ts)
                    state_next = vdes_pkg::ST_TS_OFF;
                else if (inv_disabled)
                    state_next = vdes_pkg::ST_TS_ON;
                else if (pc_to)
                    state_next = vdes_pkg::ST_TS_OFF;
            end
            default:
                // startup, and unused codes behave the same
                state_next = vdes_pkg::ST_TS_OFF;
        endcase

        changed = (state_next != state_reg);
        // timer restarts on entry to the buzzer state
        if (changed && state_next == vdes_pkg::ST_BUZZER)
            buzzer_elapsed_next = '0;

        result_next.vehicle_state    = state_next;
        result_next.state_changed    = changed;
        result_next.buzzer_on        = (state_next == vdes_pkg::ST_BUZZER);
        result_next.lowside_on       = (state_next == vdes_pkg::ST_READY);
        result_next.kick_command     = kick;
        result_next.precharge_start  = pc_start;
        result_next.precharge_reset  = changed && (state_reg == vdes_pkg::ST_TS_ON
                                                || state_reg == vdes_pkg::ST_READY);
        result_next.fault_clear      = changed && (state_reg == vdes_pkg::ST_TS_OFF
                                                || state_next == vdes_pkg::ST_ENABLING);
        result_next.force_discharge  = changed && (state_next == vdes_pkg::ST_TS_OFF);
        result_next.inverter_startup = changed && (state_next == vdes_pkg::ST_ENABLING);
        result_next.overcurrent      = ({1'b0, current} > oc_limit);
    end

    // Checks
    a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (result_reg.vehicle_state == state_reg))
        else $error("result state differs from state register");

    a_discharge_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && result_reg.force_discharge) |->
        (result_reg.state_changed && result_reg.vehicle_state == vdes_pkg::ST_TS_OFF))
        else $error("discharge pulse without entry to TS inactive");

    a_startup_clears_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && result_reg.inverter_startup) |-> result_reg.fault_clear)
        else $error("inverter startup without fault clear");

    a_timer_holds_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(accept) |-> ($stable(buzzer_elapsed_reg) && $stable(state_reg)))
        else $error("sequencer state moved without a transfer");

endmodule

// File: tb/vehicle_drive_enable_sequencer_core_tb.sv
// ----------------------------------------------------------------------------
// vehicle_drive_enable_sequencer_core_tb - drive-enable sequencer testbench
// A directed table walks the sequencer through every state and most exit paths.
// Biased random control-loop passes follow under several threshold and buzzer
// settings and several back-pressure patterns. Each result transfer is checked
// field by field against a table entry or a local model of the sequence.
// ----------------------------------------------------------------------------
module vehicle_drive_enable_sequencer_core_tb;

    localparam int DirRows       = 24;
    localparam int PhaseCount    = 6;
    localparam int RxHoldCycles  = 300;
    localparam int DrainLimit    = 20000;
    localparam int ReportLimit   = 10;

    // One control-loop pass, ts_active in bit 0
    typedef struct packed {
        logic [vdes_pkg::CurrentWidth-1:0] current;
        logic [vdes_pkg::ElapsedWidth-1:0] elapsed;
        logic                              inv_timeout;
        logic                              inv_disabled;
        logic                              inv_ready;
        logic                              brake;
        logic                              start_button;
        logic                              pc_tried;
        logic                              pc_timed_out;
        logic                              pc_ok;
        logic                              ts_active;
    } pass_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [vdes_pkg::InDataWidth-1:0]   s_tdata;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [vdes_pkg::OutDataWidth-1:0]  m_tdata;
    logic                               cfg_wr_en;
    logic [vdes_pkg::CfgIndexWidth-1:0] cfg_index;
    logic [vdes_pkg::CfgDataWidth-1:0]  cfg_data;

    // Local copy of the sequencer state and registers
    vdes_pkg::state_t                    seq_state;
    logic [vdes_pkg::DurationWidth-1:0]  buzz_ms;
    logic [vdes_pkg::ThresholdWidth-1:0] oc_limit;
    logic [vdes_pkg::DurationWidth-1:0]  buzz_dur;

    vdes_pkg::result_t pending_results[$];
    int unsigned       mismatch_count;
    int unsigned       tx_idle_pct;
    int unsigned       rx_stall_pct;
    bit                long_buzz;
    int unsigned       rx_hold_req;

    pass_t             dir_in    [DirRows];
    vdes_pkg::result_t dir_want  [DirRows];
    bit                dir_typed [DirRows];

    vehicle_drive_enable_sequencer_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3200000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence model: one pass, updates the local state
    // ------------------------------------------------------------------------
    function automatic vdes_pkg::result_t sequence_pass(pass_t p);
        vdes_pkg::result_t r;
        vdes_pkg::state_t  prev;
        vdes_pkg::state_t  nxt;
        vdes_pkg::kick_t   kick;
        logic              pc_start;
        logic              moved;
        logic [16:0]       acc;
        int unsigned       lim;
        prev     = seq_state;
        nxt      = prev;
        kick     = vdes_pkg::KICK_NONE;
        pc_start = 1'b0;
        case (prev)
            vdes_pkg::ST_TS_OFF:
            begin
                kick = vdes_pkg::KICK_DISABLE;
                if (!p.pc_tried || (p.pc_timed_out && !p.pc_ok))
                    pc_start = 1'b1;
                if (p.pc_ok && !p.pc_timed_out && p.ts_active)
                    nxt = vdes_pkg::ST_TS_ON;
            end
            vdes_pkg::ST_TS_ON:
            begin
                // fault exit wins over a start request
                kick = vdes_pkg::KICK_DISABLE;
                if (!p.ts_active || p.pc_timed_out)
                    nxt = vdes_pkg::ST_TS_OFF;
                else if (!p.start_button && p.brake)
                    nxt = vdes_pkg::ST_ENABLING;
            end
            vdes_pkg::ST_ENABLING:
            begin
                kick = vdes_pkg::KICK_ENABLE;
                if (!p.ts_active || p.pc_timed_out)
                    nxt = vdes_pkg::ST_TS_OFF;
                else if (p.inv_timeout)
                    nxt = vdes_pkg::ST_TS_ON;
                else if (p.inv_ready)
                    nxt = vdes_pkg::ST_BUZZER;
            end
            vdes_pkg::ST_BUZZER:
            begin
                // timer saturates at full scale
                kick = vdes_pkg::KICK_ENABLE;
                acc  = {1'b0, buzz_ms} + {9'd0, p.elapsed};
                buzz_ms = acc[16] ? 16'hFFFF : acc[15:0];
                if (!p.ts_active)
                    nxt = vdes_pkg::ST_TS_OFF;
                else if (p.inv_disabled)
                    nxt = vdes_pkg::ST_TS_ON;
                else if (buzz_ms >= buzz_dur)
                    nxt = vdes_pkg::ST_READY;
            end
            vdes_pkg::ST_READY:
            begin
                if (!p.ts_active)
                    nxt = vdes_pkg::ST_TS_OFF;
                else if (p.inv_disabled)
                    nxt = vdes_pkg::ST_TS_ON;
                else if (p.pc_timed_out)
                    nxt = vdes_pkg::ST_TS_OFF;
            end
            default:
                nxt = vdes_pkg::ST_TS_OFF;
        endcase
        moved = (nxt != prev);
        if (moved && nxt == vdes_pkg::ST_BUZZER)
            buzz_ms = '0;
        seq_state = nxt;
        lim = oc_limit * vdes_pkg::CurrentScale;
        r.vehicle_state    = nxt;
        r.state_changed    = moved;
        r.buzzer_on        = (nxt == vdes_pkg::ST_BUZZER);
        r.lowside_on       = (nxt == vdes_pkg::ST_READY);
        r.kick_command     = kick;
        r.precharge_start  = pc_start;
        r.precharge_reset  = moved && (prev == vdes_pkg::ST_TS_ON
                                    || prev == vdes_pkg::ST_READY);
        r.fault_clear      = moved && (prev == vdes_pkg::ST_TS_OFF
                                    || nxt == vdes_pkg::ST_ENABLING);
        r.force_discharge  = moved && (nxt == vdes_pkg::ST_TS_OFF);
        r.inverter_startup = moved && (nxt == vdes_pkg::ST_ENABLING);
        r.overcurrent      = (p.current > lim);
        return r;
    endfunction

    function automatic pass_t pass_of(bit ts, bit ok, bit pto, bit tried, bit btn,
                                      bit brk, bit rdy, bit dis, bit tmo,
                                      logic [7:0] el, logic [15:0] cur);
        pass_t p;
        p.ts_active    = ts;
        p.pc_ok        = ok;
        p.pc_timed_out = pto;
        p.pc_tried     = tried;
        p.start_button = btn;
        p.brake        = brk;
        p.inv_ready    = rdy;
        p.inv_disabled = dis;
        p.inv_timeout  = tmo;
        p.elapsed      = el;
        p.current      = cur;
        return p;
    endfunction

    function automatic vdes_pkg::result_t res_of(vdes_pkg::state_t st, bit chg,
                                                 vdes_pkg::kick_t k, bit pcs, bit pcr,
                                                 bit fcl, bit dchg, bit stu, bit oc);
        vdes_pkg::result_t r;
        r.vehicle_state    = st;
        r.state_changed    = chg;
        r.buzzer_on        = (st == vdes_pkg::ST_BUZZER);
        r.lowside_on       = (st == vdes_pkg::ST_READY);
        r.kick_command     = k;
        r.precharge_start  = pcs;
        r.precharge_reset  = pcr;
        r.fault_clear      = fcl;
        r.force_discharge  = dchg;
        r.inverter_startup = stu;
        r.overcurrent      = oc;
        return r;
    endfunction

    // Random pass, mostly plausible flags so the sequence gets past TS inactive
    function automatic pass_t draw_pass();
        pass_t       p;
        logic [63:0] bits;
        int unsigned lim;
        bits = {$urandom(), $urandom()};
        p    = bits[$bits(pass_t)-1:0];
        if ($urandom_range(99) >= 12)
        begin
            p.ts_active    = ($urandom_range(99) < 96);
            p.pc_timed_out = ($urandom_range(99) < 4);
            p.pc_ok        = ($urandom_range(99) < 85);
            p.start_button = ($urandom_range(99) >= 45);
            p.brake        = ($urandom_range(99) < 70);
            p.inv_ready    = ($urandom_range(99) < 45);
            p.inv_disabled = ($urandom_range(99) < 6);
            p.inv_timeout  = ($urandom_range(99) < 8);
            if (long_buzz && seq_state == vdes_pkg::ST_BUZZER)
            begin
                p.ts_active    = 1'b1;
                p.inv_disabled = 1'b0;
                p.elapsed      = 8'($urandom_range(255, 128));
            end
            // currents around the overcurrent boundary
            lim = oc_limit * vdes_pkg::CurrentScale;
            if ($urandom_range(3) == 0)
                p.current = (lim > 65534) ? 16'hFFFF : 16'(lim + $urandom_range(1));
        end
        return p;
    endfunction

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= ReportLimit)
            $display("%s", msg);
    endtask

    // One input transfer; the sender idles cycle by cycle at the set rate
    task automatic push_pass(input pass_t p, input bit typed,
                             input vdes_pkg::result_t want);
        vdes_pkg::result_t r;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vdes_pkg::InDataWidth'(p);
        do
            @(posedge clk);
        while (!s_tready);
        r = sequence_pass(p);
        pending_results.push_back(typed ? want : r);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (pending_results.size() != 0 && n < DrainLimit);
    endtask

    task automatic write_reg(input logic [vdes_pkg::CfgIndexWidth-1:0] idx,
                             input logic [vdes_pkg::CfgDataWidth-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx == vdes_pkg::REG_OC_THRESHOLD)
            oc_limit = val[vdes_pkg::ThresholdWidth-1:0];
        else if (idx == vdes_pkg::REG_BUZZER_DURATN)
            buzz_dur = val;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        int unsigned hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != rx_hold_req)
            begin
                hold_seen = rx_hold_req;
                hold_left = RxHoldCycles;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        vdes_pkg::result_t got;
        vdes_pkg::result_t want;
        string             diff;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[$bits(vdes_pkg::result_t)-1:0];
            if (pending_results.size() == 0)
                note_failure($sformatf("unexpected result transfer %h", m_tdata));
            else
            begin
                want = pending_results.pop_front();
                diff = "";
                if (got.vehicle_state !== want.vehicle_state)
                    diff = {diff, " vehicle_state"};
                if (got.state_changed !== want.state_changed)
                    diff = {diff, " state_changed"};
                if (got.buzzer_on !== want.buzzer_on)
                    diff = {diff, " buzzer_on"};
                if (got.lowside_on !== want.lowside_on)
                    diff = {diff, " lowside_on"};
                if (got.kick_command !== want.kick_command)
                    diff = {diff, " kick_command"};
                if (got.precharge_start !== want.precharge_start)
                    diff = {diff, " precharge_start"};
                if (got.precharge_reset !== want.precharge_reset)
                    diff = {diff, " precharge_reset"};
                if (got.fault_clear !== want.fault_clear)
                    diff = {diff, " fault_clear"};
                if (got.force_discharge !== want.force_discharge)
                    diff = {diff, " force_discharge"};
                if (got.inverter_startup !== want.inverter_startup)
                    diff = {diff, " inverter_startup"};
                if (got.overcurrent !== want.overcurrent)
                    diff = {diff, " overcurrent"};
                if (m_tdata[vdes_pkg::OutDataWidth-1:$bits(vdes_pkg::result_t)] !== '0)
                    diff = {diff, " padding"};
                if (diff != "")
                    note_failure($sformatf("mismatch in%s: expected %h, got %h",
                                           diff, want, m_tdata));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned count;
        logic [vdes_pkg::CfgDataWidth-1:0] thr;
        logic [vdes_pkg::CfgDataWidth-1:0] dur;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        rst_n          = 1'b0;
        tx_idle_pct    = 24;
        rx_stall_pct   = 62;
        long_buzz      = 1'b0;
        rx_hold_req    = 0;
        mismatch_count = 0;
        seq_state      = vdes_pkg::ST_STARTUP;
        buzz_ms        = '0;
        oc_limit       = vdes_pkg::OcThresholdReset;
        buzz_dur       = vdes_pkg::BuzzerDurReset;

        // Directed walk: args ts ok pto tried btn brk rdy dis tmo el cur
        foreach (dir_typed[i])
            dir_typed[i] = 1'b0;
        // startup leaves at once, full-scale current
        dir_in[0]  = pass_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 8'd0, 16'hFFFF);
        dir_want[0]  = res_of(vdes_pkg::ST_TS_OFF, 1, vdes_pkg::KICK_NONE,
                              0, 0, 0, 1, 0, 1);
        dir_typed[0] = 1'b1;
        // no attempt yet: precharge start, current exactly at the limit
        dir_in[1]  = pass_of(1, 0, 0, 0, 1, 0, 0, 0, 0, 8'd10, 16'd1000);
        dir_want[1]  = res_of(vdes_pkg::ST_TS_OFF, 0, vdes_pkg::KICK_DISABLE,
                              1, 0, 0, 0, 0, 0);
        dir_typed[1] = 1'b1;
        // every flag set: timeout blocks the precharge exit
        dir_in[2]  = pass_of(1, 1, 1, 1, 1, 1, 1, 1, 1, 8'hFF, 16'hFFFF);
        dir_want[2]  = res_of(vdes_pkg::ST_TS_OFF, 0, vdes_pkg::KICK_DISABLE,
                              0, 0, 0, 0, 0, 1);
        dir_typed[2] = 1'b1;
        dir_in[3]  = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd0, 16'd0);
        dir_want[3]  = res_of(vdes_pkg::ST_TS_ON, 1, vdes_pkg::KICK_DISABLE,
                              0, 0, 1, 0, 0, 0);
        dir_typed[3] = 1'b1;
        // fault and start request in the same pass
        dir_in[4]  = pass_of(1, 1, 1, 1, 0, 1, 0, 0, 0, 8'd0, 16'd1001);
        dir_want[4]  = res_of(vdes_pkg::ST_TS_OFF, 1, vdes_pkg::KICK_DISABLE,
                              0, 1, 0, 1, 0, 1);
        dir_typed[4] = 1'b1;
        dir_in[5]  = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd3, 16'd999);
        dir_in[6]  = pass_of(1, 1, 0, 1, 0, 0, 0, 0, 0, 8'd7, 16'd1234);
        dir_in[7]  = pass_of(1, 1, 0, 1, 1, 1, 0, 0, 0, 8'd1, 16'd40);
        dir_in[8]  = pass_of(1, 1, 0, 1, 0, 1, 0, 0, 0, 8'd0, 16'd0);
        dir_want[8]  = res_of(vdes_pkg::ST_ENABLING, 1, vdes_pkg::KICK_DISABLE,
                              0, 1, 1, 0, 1, 0);
        dir_typed[8] = 1'b1;
        // enable timeout beats inverter ready
        dir_in[9]  = pass_of(1, 1, 0, 1, 1, 0, 1, 0, 1, 8'd9, 16'd2000);
        dir_in[10] = pass_of(1, 1, 0, 1, 0, 1, 0, 0, 0, 8'd0, 16'd5);
        dir_in[11] = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd200, 16'd77);
        dir_in[12] = pass_of(1, 1, 0, 1, 1, 0, 1, 0, 0, 8'd100, 16'd300);
        // buzzer one short of the duration, then inverter drops out
        dir_in[13] = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd254, 16'd8);
        dir_in[14] = pass_of(1, 1, 0, 1, 1, 0, 0, 1, 0, 8'd0, 16'd9);
        dir_in[15] = pass_of(1, 1, 0, 1, 0, 1, 0, 0, 0, 8'd1, 16'd4000);
        dir_in[16] = pass_of(1, 1, 0, 1, 1, 0, 1, 0, 0, 8'd2, 16'd12);
        // buzzer reaches the duration exactly
        dir_in[17] = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd255, 16'd6);
        dir_in[18] = pass_of(1, 1, 1, 1, 1, 0, 0, 0, 0, 8'd0, 16'd0);
        dir_want[18]  = res_of(vdes_pkg::ST_TS_OFF, 1, vdes_pkg::KICK_NONE,
                               0, 1, 0, 1, 0, 0);
        dir_typed[18] = 1'b1;
        dir_in[19] = pass_of(1, 1, 0, 1, 1, 0, 0, 0, 0, 8'd4, 16'd333);
        dir_in[20] = pass_of(1, 1, 0, 1, 0, 1, 0, 0, 0, 8'd4, 16'd444);
        dir_in[21] = pass_of(1, 1, 0, 1, 1, 0, 1, 0, 0, 8'd4, 16'd555);
        dir_in[22] = pass_of(0, 1, 0, 1, 1, 0, 0, 0, 0, 8'd4, 16'd666);
        dir_in[23] = pass_of(0, 0, 0, 0, 1, 0, 0, 0, 0, 8'd0, 16'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // threshold stays at its reset value for the table
        write_reg(vdes_pkg::REG_BUZZER_DURATN, 16'd255);
        for (int i = 0; i < DirRows; i++)
            push_pass(dir_in[i], dir_typed[i], dir_want[i]);

        // Random phases: each writes both registers while idle
        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            drain_results();
            case (ph)
                0:       begin thr = 16'd0;    dur = 16'd1;     end
                1:       begin thr = 16'd6553; dur = 16'd500;   end
                2:       begin thr = 16'hFFFF; dur = 16'hFFFF;  end
                3:       begin thr = 16'd100;  dur = 16'd2000;  end
                4:       begin thr = 16'($urandom_range(6553)); dur = 16'd0; end
                default: begin
                             thr = 16'($urandom_range(6553));
                             dur = 16'($urandom_range(3000, 1));
                         end
            endcase
            tx_idle_pct  = (ph < 2) ? 24 : (ph < 4) ? 62 : 0;
            rx_stall_pct = (ph < 2) ? 62 : (ph < 4) ? 24 : 0;
            long_buzz    = (ph == 2);
            count        = (ph == 2) ? 400 : 210;
            write_reg(vdes_pkg::REG_OC_THRESHOLD, thr);
            write_reg(vdes_pkg::REG_BUZZER_DURATN, dur);
            for (int n = 0; n < count; n++)
            begin
                // long receiver hold-off while items keep coming
                if (n == 40 && (ph == 0 || ph == 4))
                    rx_hold_req <= rx_hold_req + 1;
                // pause until everything sent has come back
                if (n == 120)
                    drain_results();
                push_pass(draw_pass(), 1'b0, '0);
            end
        end

        // Closing drain
        drain_results();
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
            note_failure($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: vehicle_drive_enable_sequencer_core.f
rtl/vdes_pkg.sv
rtl/vehicle_drive_enable_sequencer_core.sv
tb/vehicle_drive_enable_sequencer_core_tb.sv
